// File: hw/rtl/iee_pkg.sv
package iee_pkg;

    // Widths of the fields on the channels and the default datapath width.
    localparam int CHAR_WIDTH     = 8;
    localparam int TOTAL_WIDTH    = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Character codes that the evaluator recognizes.
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_WIDTH-1:0] CH_MUL   = 8'd42;
    localparam logic [CHAR_WIDTH-1:0] CH_DIV   = 8'd47;
    localparam logic [CHAR_WIDTH-1:0] CH_EQ    = 8'd61;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'd48;

    // Operator that is pending inside the open term.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } t_op;

    // Operator character that started the current closing sequence.
    typedef enum logic [2:0] {
        K_MUL,
        K_DIV,
        K_PLUS,
        K_MINUS,
        K_EQ
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIGIT,
        S_CLOSE,
        S_MUL,
        S_DIV,
        S_DFIX,
        S_AFTER,
        S_TERM,
        S_EMIT
    } t_state;

endpackage

// File: hw/rtl/iee_if.sv
interface iee_char_if;
    import iee_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface iee_result_if;
    import iee_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [TOTAL_WIDTH-1:0] total;
    logic                          divide_by_zero;

    modport source (output valid, output total, output divide_by_zero, input ready);
    modport sink   (input valid, input total, input divide_by_zero, output ready);
endinterface

// File: hw/rtl/infix_expression_evaluator_top.sv
// Infix expression evaluator. Characters of an expression such as "12+3*4/2-5=" arrive one
// beat at a time on i_char; spaces are skipped, * and / bind tighter than + and -, and on '='
// the total and a divide-by-zero flag leave as one beat on o_result, after which the evaluator
// starts a fresh expression. All arithmetic wraps at DATA_WIDTH bits; the total carries the
// low 32 bits. A space is simply skipped. A digit rebuilds the running number as
// number*10 + digit through a bit-serial adder, one bit per cycle. An operator closes a
// plain number directly, a pending multiply through a shift-and-add unit, one multiplier bit
// per cycle, and a pending divide through a restoring divider, one quotient bit per cycle,
// plus a sign fix; a zero divisor instead sets the divide-by-zero flag and a zero term.
// Then +, - or = adds the term into the total bit-serially, and = also loads the result
// register. The longest character is therefore an = that closes a pending divide: the
// divider and its sign fix, the add and the load. The result register parts the two sides:
// the evaluator keeps taking characters while a finished total waits on o_result, and only
// a second '=' waits for that beat to leave.
module infix_expression_evaluator_top #(
    parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iee_char_if.sink          i_char,
    iee_result_if.source      o_result
);
    import iee_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] CNT_MAX = CW'(DATA_WIDTH - 1);

    // Architectural state of the evaluator.
    logic [DATA_WIDTH-1:0] r_num,   n_num;    // number being entered
    logic [DATA_WIDTH-1:0] r_term,  n_term;   // product or quotient of the open term
    logic [DATA_WIDTH-1:0] r_total, n_total;  // sum of the closed terms
    t_op                   r_op,    n_op;
    logic                  r_sign,  n_sign;   // open term is subtracted when set
    logic                  r_dz,    n_dz;

    // Sequencer and work registers of the serial units.
    t_state                r_state, n_state;
    t_kind                 r_kind,  n_kind;
    logic [CW-1:0]         r_cnt,   n_cnt;
    logic [DATA_WIDTH-1:0] r_d,     n_d;      // digit value, shifted out LSB first
    logic [2:0]            r_hist,  n_hist;   // last three number bits shifted out
    logic [1:0]            r_cy,    n_cy;     // serial carry
    logic [DATA_WIDTH-1:0] r_wa,    n_wa;     // multiplicand or dividend / quotient
    logic [DATA_WIDTH-1:0] r_wb,    n_wb;     // multiplier or divisor
    logic [DATA_WIDTH-1:0] r_wr,    n_wr;     // product or partial remainder
    logic                  r_neg,   n_neg;    // quotient takes a minus sign

    // Result register.
    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_WIDTH-1:0] r_out_total, n_out_total;
    logic                   r_out_dz,    n_out_dz;

    logic signed [CHAR_WIDTH:0] w_digit;
    logic [2:0]                 w_dsum;
    logic                       w_tbit;
    logic [1:0]                 w_asum;
    logic [DATA_WIDTH-1:0]      w_prod;
    logic [DATA_WIDTH-1:0]      w_rs;
    logic                       w_ge;

    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // Any character that is not a space or an operator counts as a digit worth code - 48.
    assign w_digit = $signed({1'b0, i_char.char_code}) - $signed({1'b0, CH_ZERO});

    // Serial number*10 + digit: bit i sums number bits i-1 and i-3, digit bit i and the carry.
    assign w_dsum = 3'(r_hist[2]) + 3'(r_hist[0]) + 3'(r_d[0]) + 3'(r_cy);

    // Serial add or subtract of the open term into the total.
    assign w_tbit = r_term[0] ^ r_sign;
    assign w_asum = 2'(r_total[0]) + 2'(w_tbit) + 2'(r_cy[0]);

    assign w_prod = r_wb[0] ? (r_wr + r_wa) : r_wr;

    // Restoring division step; the remainder stays below 2^(W-1), so its top bit is zero.
    assign w_rs = {r_wr[DATA_WIDTH-2:0], r_wa[DATA_WIDTH-1]};
    assign w_ge = (w_rs >= r_wb);

    assign i_char.ready           = (r_state == S_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.total         = r_out_total;
    assign o_result.divide_by_zero = r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_term      <= '0;
            r_total     <= '0;
            r_op        <= OP_NONE;
            r_sign      <= 1'b0;
            r_dz        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_term      <= n_term;
            r_total     <= n_total;
            r_op        <= n_op;
            r_sign      <= n_sign;
            r_dz        <= n_dz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_cnt       <= n_cnt;
        r_d         <= n_d;
        r_hist      <= n_hist;
        r_cy        <= n_cy;
        r_wa        <= n_wa;
        r_wb        <= n_wb;
        r_wr        <= n_wr;
        r_neg       <= n_neg;
        r_out_total <= n_out_total;
        r_out_dz    <= n_out_dz;
    end

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_term      = r_term;
        n_total     = r_total;
        n_op        = r_op;
        n_sign      = r_sign;
        n_dz        = r_dz;
        n_kind      = r_kind;
        n_cnt       = r_cnt;
        n_d         = r_d;
        n_hist      = r_hist;
        n_cy        = r_cy;
        n_wa        = r_wa;
        n_wb        = r_wb;
        n_wr        = r_wr;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out_total = r_out_total;
        n_out_dz    = r_out_dz;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_char.valid) begin
                    case (i_char.char_code)
                        CH_SPACE: begin
                            n_state = S_IDLE;
                        end
                        CH_MUL: begin
                            n_kind  = K_MUL;
                            n_state = S_CLOSE;
                        end
                        CH_DIV: begin
                            n_kind  = K_DIV;
                            n_state = S_CLOSE;
                        end
                        CH_PLUS: begin
                            n_kind  = K_PLUS;
                            n_state = S_CLOSE;
                        end
                        CH_MINUS: begin
                            n_kind  = K_MINUS;
                            n_state = S_CLOSE;
                        end
                        CH_EQ: begin
                            n_kind  = K_EQ;
                            n_state = S_CLOSE;
                        end
                        default: begin
                            n_d     = DATA_WIDTH'(w_digit);
                            n_hist  = '0;
                            n_cy    = '0;
                            n_cnt   = CNT_MAX;
                            n_state = S_DIGIT;
                        end
                    endcase
                end
            end

            S_DIGIT: begin
                n_num  = {w_dsum[0], r_num[DATA_WIDTH-1:1]};
                n_hist = {r_hist[1:0], r_num[0]};
                n_cy   = w_dsum[2:1];
                n_d    = {r_d[DATA_WIDTH-1], r_d[DATA_WIDTH-1:1]};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end
            end

            S_CLOSE: begin
                n_num = '0;
                n_cnt = CNT_MAX;
                case (r_op)
                    OP_MUL: begin
                        n_wa    = r_term;
                        n_wb    = r_num;
                        n_wr    = '0;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        if (r_num == '0) begin
                            n_term  = '0;
                            n_dz    = 1'b1;
                            n_state = S_AFTER;
                        end else begin
                            n_wa    = magnitude(r_term);
                            n_wb    = magnitude(r_num);
                            n_wr    = '0;
                            n_neg   = r_term[DATA_WIDTH-1] ^ r_num[DATA_WIDTH-1];
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        n_term  = r_num;
                        n_state = S_AFTER;
                    end
                endcase
            end

            S_MUL: begin
                n_wr  = w_prod;
                n_wa  = {r_wa[DATA_WIDTH-2:0], 1'b0};
                n_wb  = {1'b0, r_wb[DATA_WIDTH-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_term  = w_prod;
                    n_state = S_AFTER;
                end
            end

            S_DIV: begin
                n_wr  = w_ge ? (w_rs - r_wb) : w_rs;
                n_wa  = {r_wa[DATA_WIDTH-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DFIX;
                end
            end

            S_DFIX: begin
                // The most negative value over minus one wraps back to itself here.
                n_term  = r_neg ? (~r_wa + 1'b1) : r_wa;
                n_state = S_AFTER;
            end

            S_AFTER: begin
                case (r_kind)
                    K_MUL: begin
                        n_op    = OP_MUL;
                        n_state = S_IDLE;
                    end
                    K_DIV: begin
                        n_op    = OP_DIV;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_cy    = {1'b0, r_sign};
                        n_cnt   = CNT_MAX;
                        n_state = S_TERM;
                    end
                endcase
            end

            S_TERM: begin
                // The term shifts out with zero fill, so it is clear when the add ends.
                n_total = {w_asum[0], r_total[DATA_WIDTH-1:1]};
                n_term  = {1'b0, r_term[DATA_WIDTH-1:1]};
                n_cy    = {1'b0, w_asum[1]};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_op = OP_NONE;
                    case (r_kind)
                        K_PLUS: begin
                            n_sign  = 1'b0;
                            n_state = S_IDLE;
                        end
                        K_MINUS: begin
                            n_sign  = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_total = TOTAL_WIDTH'(r_total);
                    n_out_dz    = r_dz;
                    n_total     = '0;
                    n_sign      = 1'b0;
                    n_dz        = 1'b0;
                    n_op        = OP_NONE;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/iee_checker.sv
module iee_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic [iee_pkg::CHAR_WIDTH-1:0]     i_char_code,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [iee_pkg::TOTAL_WIDTH-1:0] i_total,
    input logic                               i_divide_by_zero
);
    import iee_pkg::*;

    logic w_in_beat;
    logic w_is_space;
    logic w_is_op;

    assign w_in_beat  = i_in_valid && i_in_ready;
    assign w_is_space = (i_char_code == CH_SPACE);
    assign w_is_op    = (i_char_code == CH_PLUS) || (i_char_code == CH_MINUS) ||
                        (i_char_code == CH_MUL) || (i_char_code == CH_DIV) ||
                        (i_char_code == CH_EQ);

    // A result beat that is held back keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_total) &&
        $stable(i_divide_by_zero))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A skipped space leaves the evaluator ready in the next cycle; a digit or operator keeps it busy.
    a_space_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_is_space |=> i_in_ready)
        else $error("evaluator busy after a space");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && !w_is_space |=> !i_in_ready)
        else $error("evaluator free right after a digit or operator");

    // A new result is loaded only from the emit step, during which no character is taken.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready) && !$past(w_is_op && w_in_beat))
        else $error("result appeared without an emit step");

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_char.valid),
    .i_in_ready       (i_char.ready),
    .i_char_code      (i_char.char_code),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_total          (o_result.total),
    .i_divide_by_zero (o_result.divide_by_zero)
);
